// ===== src/dhgr_pkg.sv =====
// Shared types, constants and helper functions for the double-hires unpacker.
package dhgr_pkg;

   // Frame geometry.
   localparam int ROWS_PER_FRAME = 192;
   localparam int GROUPS_PER_ROW = 20;

   // Field widths.
   localparam int ADDR_W  = 14;
   localparam int BYTE_W  = 7;
   localparam int COL_W   = 5;
   localparam int ROW_W   = 8;
   localparam int WIN_W   = 7;
   localparam int PAL_W   = 3;
   localparam int COLOR_W = 4;
   localparam int CNT_W   = 3;
   localparam int PEND_W  = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int RSP_DATA_W = 48;

   // Hires address steps.
   localparam logic [ADDR_W-1:0] HIRES_BASE       = 14'h2000;
   localparam logic [ADDR_W-1:0] ROW_IN_CELL_STEP = 14'h0400;
   localparam logic [ADDR_W-1:0] CELL_STEP        = 14'h0080;
   localparam logic [ADDR_W-1:0] THIRD_STEP       = 14'h0028;

   // Palette codes.
   localparam logic [PAL_W-1:0] PAL_DEFAULT = 3'd0;
   localparam logic [PAL_W-1:0] PAL_GREEN   = 3'd1;
   localparam logic [PAL_W-1:0] PAL_BLUE    = 3'd2;
   localparam logic [PAL_W-1:0] PAL_RED     = 3'd3;
   localparam logic [PAL_W-1:0] PAL_YELLOW  = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_SELECT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_FIRST   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LAST    = 2'd2;

   // Result of assembling one input item against the pending indices.
   typedef struct packed {
      logic              group_done;
      logic [PEND_W-1:0] next_pending;
      logic [CNT_W-1:0]  next_count;
      logic [BYTE_W-1:0] aux_first;
      logic [BYTE_W-1:0] main_first;
      logic [BYTE_W-1:0] aux_second;
      logic [BYTE_W-1:0] main_second;
   } pack_result_type;

   // Position of the current group on screen.
   typedef struct packed {
      logic [ADDR_W-1:0] main_address;
      logic              in_window;
      logic              frame_end;
   } scan_info_type;

   // Map one 2-bit index through the selected palette; unknown codes use the default.
   function automatic logic [COLOR_W-1:0] palette_color(input logic [PAL_W-1:0] sel,
                                                        input logic [1:0] idx);
      logic [COLOR_W-1:0] color;
      case (sel)
         PAL_GREEN: begin
            case (idx)
               2'd0: color = 4'd0;
               2'd1: color = 4'd2;
               2'd2: color = 4'd6;
               default: color = 4'd14;
            endcase
         end
         PAL_BLUE: begin
            case (idx)
               2'd0: color = 4'd0;
               2'd1: color = 4'd1;
               2'd2: color = 4'd3;
               default: color = 4'd11;
            endcase
         end
         PAL_RED: begin
            case (idx)
               2'd0: color = 4'd0;
               2'd1: color = 4'd8;
               2'd2: color = 4'd9;
               default: color = 4'd13;
            endcase
         end
         PAL_YELLOW: begin
            case (idx)
               2'd0: color = 4'd0;
               2'd1: color = 4'd4;
               2'd2: color = 4'd12;
               default: color = 4'd14;
            endcase
         end
         default: begin
            case (idx)
               2'd0: color = 4'd0;
               2'd1: color = 4'd5;
               2'd2: color = 4'd11;
               default: color = 4'd15;
            endcase
         end
      endcase
      return color;
   endfunction

   // Interleaved hires address of the first byte of a row.
   function automatic logic [ADDR_W-1:0] row_address(input logic [ROW_W-1:0] row);
      logic [ADDR_W-1:0] in_cell;
      logic [ADDR_W-1:0] cell_part;
      logic [ADDR_W-1:0] third;
      in_cell   = {11'd0, row[2:0]} * ROW_IN_CELL_STEP;
      cell_part = {11'd0, row[5:3]} * CELL_STEP;
      third     = {12'd0, row[7:6]} * THIRD_STEP;
      return HIRES_BASE + in_cell + cell_part + third;
   endfunction

endpackage

// ===== src/dhgr_group_pack.sv =====
// Index queue assembly, palette lookup and double-hires byte packing for one item.
module dhgr_group_pack (
   input  logic [7:0]                   packed_byte,
   input  logic [dhgr_pkg::PEND_W-1:0]  pending,
   input  logic [dhgr_pkg::CNT_W-1:0]   count,
   input  logic [dhgr_pkg::PAL_W-1:0]   palette_select,
   output dhgr_pkg::pack_result_type    result
);
   import dhgr_pkg::*;

   logic [PEND_W-1:0]  pending_masked;
   logic [19:0]        queue;
   logic [COLOR_W-1:0] c [7];

   // Keep only the queued indices, then append the four new ones behind them.
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         pending_masked[2*i +: 2] = (CNT_W'(i) < count) ? pending[2*i +: 2] : 2'b00;
      end
      queue = {8'd0, pending_masked} | ({12'd0, packed_byte} << {count, 1'b0});
   end

   // Seven oldest indices through the palette.
   always_comb begin
      for (int i = 0; i < 7; i++) begin
         c[i] = palette_color(palette_select, queue[2*i +: 2]);
      end
   end

   // A group completes once three or more indices were already waiting.
   always_comb begin
      result.group_done = (count >= CNT_W'(3));
      if (result.group_done) begin
         result.next_pending = {6'd0, queue[19:14]};
         result.next_count   = count - CNT_W'(3);
      end else begin
         result.next_pending = queue[PEND_W-1:0];
         result.next_count   = count + CNT_W'(4);
      end
      result.aux_first   = {c[1][2:0], c[0]};
      result.main_first  = {c[3][1:0], c[2], c[1][3]};
      result.aux_second  = {c[5][0], c[4], c[3][3:2]};
      result.main_second = {c[6], c[5][3:1]};
   end

endmodule

// ===== src/dhgr_scan_counter.sv =====
// Column and row counters with hires address, window test and frame end flag.
module dhgr_scan_counter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [dhgr_pkg::WIN_W-1:0]  window_first,
   input  logic [dhgr_pkg::WIN_W-1:0]  window_last,
   output dhgr_pkg::scan_info_type     info
);
   import dhgr_pkg::*;

   logic [COL_W-1:0] column_ff, column_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             col_wrap;
   logic             row_wrap;

   assign col_wrap = ({1'b0, column_ff} + 6'd1) >= 6'(GROUPS_PER_ROW);
   assign row_wrap = ({1'b0, row_ff} + 9'd1) >= 9'(ROWS_PER_FRAME);

   // Position of the group now being completed.
   always_comb begin
      info.main_address = row_address(row_ff) + {8'd0, column_ff, 1'b0};
      info.in_window    = ({2'd0, column_ff} >= window_first)
                          && ({2'd0, column_ff} <= window_last);
      info.frame_end    = col_wrap && row_wrap;
   end

   // Step to the next group, wrapping at row and frame ends.
   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (advance) begin
         if (col_wrap) begin
            column_in = '0;
            row_in    = row_wrap ? '0 : row_ff + ROW_W'(1);
         end else begin
            column_in = column_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

// ===== src/dhgr_two_bit_unpacker.sv =====
// Top level of the double-hires two-bit pixel unpacker.
//
//   channel  direction  payload
//   req_     in         tdata: packed_byte
//   rsp_     out        tdata: address and four packed bytes, tlast: frame_end
//   csr_     in         index 0 palette_select, 1 window_first_column, 2 window_last_column
//
// Each item passes through the input register and each result through the result register,
// and one item is taken every cycle while results drain.
// An item moves on only when the result register is free or being emptied; a
// stalled result therefore holds back at most one further item in the input register.
// Reset is synchronous and clears queue, counters, valids and the configuration.
// Every seventh index completes a group, so results appear for most but not all items.
module dhgr_two_bit_unpacker (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input item stream.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // [7:0] packed_byte
   // Result stream.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [13:0] main_address, [20:14] aux_first, [27:21] main_first,
   // [34:28] aux_second, [41:35] main_second, [47:42] zero
   output logic [dhgr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,  // frame_end
   // Configuration writes.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dhgr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dhgr_pkg::CSR_DATA_W-1:0]      csr_data
);
   import dhgr_pkg::*;

   logic [PAL_W-1:0]  palette_ff;
   logic [WIN_W-1:0]  window_first_ff;
   logic [WIN_W-1:0]  window_last_ff;

   logic              in_valid_ff;
   logic [7:0]        in_byte_ff;

   logic [PEND_W-1:0] pending_ff;
   logic [CNT_W-1:0]  count_ff;

   logic              out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic              out_last_ff;

   logic              advance;
   logic              emit;
   pack_result_type   pack;
   scan_info_type     scan;

   // Configuration is always accepted.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff      <= PAL_DEFAULT;
         window_first_ff <= '0;
         window_last_ff  <= '1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PALETTE_SELECT: palette_ff      <= csr_data[PAL_W-1:0];
            CSR_WINDOW_FIRST:   window_first_ff <= csr_data;
            CSR_WINDOW_LAST:    window_last_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // The held item moves on when the result register can take whatever it makes.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign emit       = advance && pack.group_done;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   dhgr_group_pack u_pack (
      .packed_byte    (in_byte_ff),
      .pending        (pending_ff),
      .count          (count_ff),
      .palette_select (palette_ff),
      .result         (pack)
   );

   dhgr_scan_counter u_scan (
      .clock        (clock),
      .reset        (reset),
      .advance      (emit),
      .window_first (window_first_ff),
      .window_last  (window_last_ff),
      .info         (scan)
   );

   // Pending index queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         count_ff   <= '0;
      end else if (advance) begin
         pending_ff <= pack.next_pending;
         count_ff   <= pack.next_count;
      end
   end

   // Result register.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance || rsp_tready) begin
         out_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Columns outside the window carry zero pixel bytes.
   always_ff @(posedge clock) begin
      if (emit) begin
         if (scan.in_window) begin
            out_data_ff <= {6'd0, pack.main_second, pack.aux_second,
                            pack.main_first, pack.aux_first, scan.main_address};
         end else begin
            out_data_ff <= {6'd0, 28'd0, scan.main_address};
         end
         out_last_ff <= scan.frame_end;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== src/dhgr_checker.sv =====
// Port-level assertions for the double-hires unpacker, bound to the top level.
module dhgr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [dhgr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tlast
);
   import dhgr_pkg::*;

   localparam logic [ADDR_W-1:0] LAST_ADDRESS =
      row_address(ROW_W'(ROWS_PER_FRAME - 1)) + ADDR_W'(2 * (GROUPS_PER_ROW - 1));

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Input is only held back behind a waiting result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a waiting result");

   // The frame end marks the last group of the last row.
   a_frame_end_address: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[ADDR_W-1:0] == LAST_ADDRESS)
      else $error("frame end on a group other than the last");

   // Addresses stay in the upper hires page and padding stays zero.
   a_address_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[ADDR_W-1] && rsp_tdata[RSP_DATA_W-1:42] == 6'd0)
      else $error("result address or padding out of range");

endmodule

bind dhgr_two_bit_unpacker dhgr_checker u_dhgr_checker (.*);
